### rtl/cfem_pkg.sv
`default_nettype none
package cfem_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int QUEUE_DEPTH = 65536;

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int QA_W       = $clog2(QUEUE_DEPTH);
  localparam int QD_W       = ROW_W + COL_W;

  localparam int DIM_W      = 9;
  localparam int STEP_W     = 8;
  localparam int DEPTH_W    = 3;
  localparam int THR_W      = 20;
  localparam int LVL_W      = 3;
  localparam int SUM_W      = 10;
  localparam int COUNT_W    = 17;
  localparam int LADDR_W    = ADDR_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [DEPTH_W-1:0] TOP_EXPAND = 3'd6;
  localparam logic [7:0]         COLOR_MAX  = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_GRID      = 3'd2,
    REG_MAX_DEPTH = 3'd3,
    REG_COLOR     = 3'd4,
    REG_THRESHOLD = 3'd5
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic {
    KIND_DONE = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_START,
    ST_SEED,
    ST_POP,
    ST_POP_WAIT,
    ST_IDX,
    ST_PT_READ,
    ST_PT_WAIT,
    ST_DIST,
    ST_PROBE,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_pixel;
    logic [15:0] read_index;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [LVL_W-1:0]   mark_level;
    logic [7:0]         mark_color;
    logic [COUNT_W-1:0] marked_count;
    logic               queue_overflow;
  } out_t;

  // effective settings after clamping
  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [STEP_W-1:0]  grid;
    logic [DEPTH_W-1:0] top;
    logic [7:0]         color_step;
    logic [THR_W-1:0]   threshold;
  } cfg_t;

endpackage
`default_nettype wire

### rtl/coarse_to_fine_edge_marker.sv
// Load transaction: one per cycle while the output register is free. A frame's first load
// starts a clear of all 65536 mark entries. Read transaction: result formed in ST_RD_WAIT,
// where no input is taken, then registered. Search: one grid seed per cycle, then each popped
// point passes ST_POP to ST_PT_WAIT; one that expands adds ST_DIST, then ST_PROBE and, if in
// range, ST_EVAL per direction. The report follows the empty check. Reset (rst, synchronous,
// active high): defaults, then a mark clear taking no input; config writes taken outside rst.
`default_nettype none
module coarse_to_fine_edge_marker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire cfem_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output cfem_pkg::out_t                       out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cfem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfem_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cfem_pkg::*;

  // raw configuration registers
  logic [DIM_W-1:0]   image_width, image_height;
  logic [STEP_W-1:0]  grid_step;
  logic [DEPTH_W-1:0] max_depth;
  logic [7:0]         color_step;
  logic [THR_W-1:0]   diff_threshold;

  cfg_t           cfg;
  logic           out_free;
  logic           res_valid;
  out_t           res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= DIM_W'(256);
      image_height   <= DIM_W'(256);
      grid_step      <= STEP_W'(20);
      max_depth      <= DEPTH_W'(3);
      color_step     <= 8'd85;
      diff_threshold <= THR_W'(70 * 70);
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDTH:     image_width    <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:    image_height   <= cfg_data[DIM_W-1:0];
        REG_GRID:      grid_step      <= cfg_data[STEP_W-1:0];
        REG_MAX_DEPTH: max_depth      <= cfg_data[DEPTH_W-1:0];
        REG_COLOR:     color_step     <= cfg_data[7:0];
        REG_THRESHOLD: diff_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to the supported ranges: zero size acts as 1, zero grid as 1, depth tops out at 6
  always_comb begin
    cfg.width      = (image_width == '0) ? DIM_W'(1) :
                     (image_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : image_width;
    cfg.height     = (image_height == '0) ? DIM_W'(1) :
                     (image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : image_height;
    cfg.grid       = (grid_step == '0) ? STEP_W'(1) : grid_step;
    cfg.top        = (max_depth > TOP_EXPAND) ? TOP_EXPAND : max_depth;
    cfg.color_step = color_step;
    cfg.threshold  = diff_threshold;
  end

  // output register parts the engine from the consumer
  assign out_free = !out_valid || out_ready;

  cfem_engine u_engine (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_free(out_free), .res_valid(res_valid), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

### rtl/cfem_ram.sv
`default_nettype none
module cfem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/cfem_engine.sv
`default_nettype none
module cfem_engine (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cfem_pkg::cfg_t cfg,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire cfem_pkg::in_t in_data,
  input  wire logic         out_free,
  output logic              res_valid,
  output cfem_pkg::out_t    res
);
  import cfem_pkg::*;

  state_t state, state_next;

  logic [ADDR_W-1:0]  clr_cnt, clr_cnt_next;
  logic               pending, pending_next;
  logic [LADDR_W-1:0] load_addr, load_addr_next;
  logic [COUNT_W-1:0] marked_total, marked_total_next;
  logic               ovf, ovf_next;
  logic [QA_W-1:0]    head, head_next, tail, tail_next;
  logic [QA_W:0]      fill, fill_next;
  logic               rd_in_range, rd_in_range_next;

  logic [DIM_W-1:0]   seed_r, seed_r_next, seed_c, seed_c_next;
  logic [ROW_W-1:0]   cur_r, cur_r_next, n_r, n_r_next;
  logic [COL_W-1:0]   cur_c, cur_c_next, n_c, n_c_next;
  logic [ADDR_W-1:0]  cur_idx, cur_idx_next, n_idx, n_idx_next;
  logic [LVL_W-1:0]   cur_d, cur_d_next;
  logic [SUM_W-1:0]   ps, ps_next;
  logic [STEP_W-1:0]  hop, hop_next;
  logic [ADDR_W-1:0]  hop_w, hop_w_next;
  dir_t               dir, dir_next;

  logic               mark_we, pix_we, q_we;
  logic [ADDR_W-1:0]  mark_waddr, mark_raddr, pix_raddr;
  logic [LVL_W-1:0]   mark_wdata, mark_rdata;
  logic [SUM_W-1:0]   pix_wdata, pix_rdata;
  logic [QD_W-1:0]    q_wdata, q_rdata;

  // probe and evaluate helpers
  logic [DIM_W-1:0]   r_ext, c_ext, hop_ext, r_sum, c_sum;
  logic               cond;
  logic [ROW_W-1:0]   pr;
  logic [COL_W-1:0]   pc;
  logic [ADDR_W-1:0]  pi;
  logic [LVL_W-1:0]   lvl;
  logic [SUM_W-1:0]   diff;
  logic [THR_W-1:0]   sq;
  logic [10:0]        color_full;
  logic [2*DIM_W-1:0] frame;
  logic               push_req;
  logic [QD_W-1:0]    push_data;
  logic               last_dir;

  cfem_ram #(.WIDTH(LVL_W), .DEPTH(STORE_SIZE)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(mark_raddr), .rdata(mark_rdata)
  );

  cfem_ram #(.WIDTH(SUM_W), .DEPTH(STORE_SIZE)) u_pix (
    .clk(clk), .we(pix_we), .waddr(load_addr[ADDR_W-1:0]), .wdata(pix_wdata),
    .raddr(pix_raddr), .rdata(pix_rdata)
  );

  cfem_ram #(.WIDTH(QD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .we(q_we), .waddr(tail), .wdata(q_wdata),
    .raddr(head), .rdata(q_rdata)
  );

  assign frame     = (2*DIM_W)'(cfg.width) * (2*DIM_W)'(cfg.height);
  assign pix_wdata = SUM_W'(in_data.red) + SUM_W'(in_data.green) + SUM_W'(in_data.blue);
  assign r_ext     = DIM_W'(cur_r);
  assign c_ext     = DIM_W'(cur_c);
  assign hop_ext   = DIM_W'(hop);
  assign r_sum     = r_ext + hop_ext;
  assign c_sum     = c_ext + hop_ext;
  assign diff      = (pix_rdata > ps) ? pix_rdata - ps : ps - pix_rdata;
  assign sq        = THR_W'(diff) * THR_W'(diff);
  assign lvl       = cur_d + LVL_W'(1);
  assign last_dir  = (dir == DIR_RIGHT);

  always_comb begin
    cond = 1'b0;
    pr   = cur_r;
    pc   = cur_c;
    pi   = cur_idx;
    case (dir)
      DIR_UP: begin
        cond = r_ext > hop_ext;
        pr   = ROW_W'(r_ext - hop_ext);
        pi   = cur_idx - hop_w;
      end
      DIR_DOWN: begin
        cond = r_sum < cfg.height;
        pr   = ROW_W'(r_sum);
        pi   = cur_idx + hop_w;
      end
      DIR_LEFT: begin
        cond = c_ext > hop_ext;
        pc   = COL_W'(c_ext - hop_ext);
        pi   = cur_idx - ADDR_W'(hop);
      end
      DIR_RIGHT: begin
        cond = c_sum < cfg.width;
        pc   = COL_W'(c_sum);
        pi   = cur_idx + ADDR_W'(hop);
      end
      default: begin
        cond = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next        = state;
    clr_cnt_next      = clr_cnt;
    pending_next      = pending;
    load_addr_next    = load_addr;
    marked_total_next = marked_total;
    ovf_next          = ovf;
    head_next         = head;
    tail_next         = tail;
    fill_next         = fill;
    rd_in_range_next  = rd_in_range;
    seed_r_next       = seed_r;
    seed_c_next       = seed_c;
    cur_r_next        = cur_r;
    cur_c_next        = cur_c;
    cur_idx_next      = cur_idx;
    n_r_next          = n_r;
    n_c_next          = n_c;
    n_idx_next        = n_idx;
    cur_d_next        = cur_d;
    ps_next           = ps;
    hop_next          = hop;
    hop_w_next        = hop_w;
    dir_next          = dir;
    mark_we           = 1'b0;
    mark_waddr        = n_idx;
    mark_wdata        = lvl;
    mark_raddr        = n_idx;
    pix_raddr         = n_idx;
    pix_we            = 1'b0;
    push_req          = 1'b0;
    push_data         = {n_r, n_c};
    in_ready          = 1'b0;
    res_valid         = 1'b0;
    res               = '0;
    color_full        = '0;

    case (state)
      ST_CLEAR: begin
        mark_we      = 1'b1;
        mark_waddr   = clr_cnt;
        mark_wdata   = '0;
        clr_cnt_next = clr_cnt + ADDR_W'(1);
        if (clr_cnt == ADDR_W'(STORE_SIZE - 1)) begin
          state_next = pending ? ST_START : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready   = out_free;
        mark_raddr = in_data.read_index[ADDR_W-1:0];
        if (in_valid && out_free) begin
          if (in_data.operation == OP_READ) begin
            rd_in_range_next = {1'b0, in_data.read_index} < 17'(STORE_SIZE);
            state_next       = ST_RD_WAIT;
          end else begin
            if ((2*DIM_W)'(load_addr) < frame) begin
              pix_we         = 1'b1;
              load_addr_next = load_addr + LADDR_W'(1);
            end
            if (load_addr == '0) begin
              marked_total_next = '0;
              pending_next      = in_data.last_pixel;
              clr_cnt_next      = '0;
              state_next        = ST_CLEAR;
            end else if (in_data.last_pixel) begin
              state_next = ST_START;
            end
          end
        end
      end
      ST_RD_WAIT: begin
        res.kind           = KIND_READ;
        res.mark_level     = rd_in_range ? mark_rdata : '0;
        color_full         = 11'(res.mark_level) * 11'(cfg.color_step);
        res.mark_color     = (color_full > 11'(COLOR_MAX)) ? COLOR_MAX : color_full[7:0];
        res.marked_count   = marked_total;
        res.queue_overflow = ovf;
        res_valid          = 1'b1;
        state_next         = ST_IDLE;
      end
      ST_START: begin
        head_next   = '0;
        tail_next   = '0;
        fill_next   = '0;
        ovf_next    = 1'b0;
        seed_r_next = '0;
        seed_c_next = '0;
        state_next  = ST_SEED;
      end
      ST_SEED: begin
        push_req  = 1'b1;
        push_data = {seed_r[ROW_W-1:0], seed_c[COL_W-1:0]};
        if (seed_c + DIM_W'(cfg.grid) >= cfg.width) begin
          seed_c_next = '0;
          if (seed_r + DIM_W'(cfg.grid) >= cfg.height) begin
            state_next = ST_POP;
          end else begin
            seed_r_next = seed_r + DIM_W'(cfg.grid);
          end
        end else begin
          seed_c_next = seed_c + DIM_W'(cfg.grid);
        end
      end
      ST_POP: begin
        if (fill == '0) begin
          res.kind           = KIND_DONE;
          res.marked_count   = marked_total;
          res.queue_overflow = ovf;
          res_valid          = 1'b1;
          load_addr_next     = '0;
          state_next         = ST_IDLE;
        end else begin
          head_next  = head + QA_W'(1);
          fill_next  = fill - (QA_W+1)'(1);
          state_next = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        cur_r_next = q_rdata[QD_W-1:COL_W];
        cur_c_next = q_rdata[COL_W-1:0];
        state_next = ST_IDX;
      end
      ST_IDX: begin
        cur_idx_next = ADDR_W'(cur_r) * ADDR_W'(cfg.width) + ADDR_W'(cur_c);
        state_next   = ST_PT_READ;
      end
      ST_PT_READ: begin
        mark_raddr = cur_idx;
        pix_raddr  = cur_idx;
        state_next = ST_PT_WAIT;
      end
      ST_PT_WAIT: begin
        if (mark_rdata > cfg.top) begin
          state_next = ST_POP;
        end else begin
          cur_d_next = mark_rdata;
          ps_next    = pix_rdata;
          hop_next   = ((cfg.grid >> mark_rdata) == '0) ? STEP_W'(1)
                                                        : (cfg.grid >> mark_rdata);
          dir_next   = DIR_UP;
          state_next = ST_DIST;
        end
      end
      ST_DIST: begin
        hop_w_next = ADDR_W'(hop) * ADDR_W'(cfg.width);
        state_next = ST_PROBE;
      end
      ST_PROBE: begin
        mark_raddr = pi;
        pix_raddr  = pi;
        if (cond) begin
          n_r_next   = pr;
          n_c_next   = pc;
          n_idx_next = pi;
          state_next = ST_EVAL;
        end else if (last_dir) begin
          state_next = ST_POP;
        end else begin
          dir_next = dir_t'(dir + 2'd1);
        end
      end
      ST_EVAL: begin
        if ((mark_rdata < lvl) && (sq > cfg.threshold)) begin
          mark_we  = 1'b1;
          push_req = 1'b1;
          if (mark_rdata == '0) begin
            marked_total_next = marked_total + COUNT_W'(1);
          end
        end
        if (last_dir) begin
          state_next = ST_POP;
        end else begin
          dir_next   = dir_t'(dir + 2'd1);
          state_next = ST_PROBE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // queue push; a full queue drops the point
    q_we    = 1'b0;
    q_wdata = push_data;
    if (push_req) begin
      if (fill[QA_W]) begin
        ovf_next = 1'b1;
      end else begin
        q_we      = 1'b1;
        tail_next = tail + QA_W'(1);
        fill_next = fill + (QA_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      pending      <= 1'b0;
      load_addr    <= '0;
      marked_total <= '0;
      ovf          <= 1'b0;
      head         <= '0;
      tail         <= '0;
      fill         <= '0;
    end else begin
      state        <= state_next;
      clr_cnt      <= clr_cnt_next;
      pending      <= pending_next;
      load_addr    <= load_addr_next;
      marked_total <= marked_total_next;
      ovf          <= ovf_next;
      head         <= head_next;
      tail         <= tail_next;
      fill         <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_in_range <= rd_in_range_next;
    seed_r      <= seed_r_next;
    seed_c      <= seed_c_next;
    cur_r       <= cur_r_next;
    cur_c       <= cur_c_next;
    cur_idx     <= cur_idx_next;
    n_r         <= n_r_next;
    n_c         <= n_c_next;
    n_idx       <= n_idx_next;
    cur_d       <= cur_d_next;
    ps          <= ps_next;
    hop         <= hop_next;
    hop_w       <= hop_w_next;
    dir         <= dir_next;
  end

endmodule
`default_nettype wire

### rtl/cfem_checker.sv
`default_nettype none
module cfem_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire cfem_pkg::in_t                   in_data,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire cfem_pkg::out_t                  out_data
);
  import cfem_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_DONE |->
      out_data.mark_level == '0 && out_data.mark_color == '0)
    else $error("search report carries mark data");

  a_color_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_READ && out_data.mark_level == '0 |->
      out_data.mark_color == '0)
    else $error("unmarked pixel has color");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.operation == OP_READ |=> !in_ready)
    else $error("input taken during read latency");

endmodule

bind coarse_to_fine_edge_marker cfem_checker u_cfem_checker (.*);
`default_nettype wire
